[design/igta_pkg.sv]
package igta_pkg;

    localparam int DEF_MAX_TRACKS = 64;
    localparam logic [8:0] THRESH_RESET = 9'd77;
    localparam logic [7:0] MAX_AGE_RESET = 8'd30;
    localparam logic [7:0] AGE_SAT = 8'd255;
    localparam logic [30:0] THRESH_DEN = 31'd256;

    // configuration register indexes
    localparam logic REG_IOU_THRESHOLD = 1'b0;
    localparam logic REG_MAX_AGE = 1'b1;

    // input commands
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_DETECT = 1'b1;

    // one stored track
    typedef struct packed {
        logic        valid;
        logic [15:0] left;
        logic [15:0] top;
        logic [14:0] width;
        logic [14:0] height;
        logic [7:0]  cls;
        logic [7:0]  age;
        logic [31:0] track;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // outcome flags of one scan
    typedef struct packed {
        logic best_found;
        logic free_found;
    } scan_flags_t;

    // extent of overlap of [a0, a0+al) and [b0, b0+bl), zero if none
    function automatic logic [14:0] overlap_1d(
        input logic [15:0] a0,
        input logic [14:0] al,
        input logic [15:0] b0,
        input logic [14:0] bl
    );
        logic signed [17:0] as, bs, ae, be, lo, hi, diff;
        as = $signed({{2{a0[15]}}, a0});
        bs = $signed({{2{b0[15]}}, b0});
        ae = as + $signed({3'b000, al});
        be = bs + $signed({3'b000, bl});
        lo = (as > bs) ? as : bs;
        hi = (ae < be) ? ae : be;
        diff = hi - lo;
        return (hi > lo) ? diff[14:0] : 15'd0;
    endfunction

endpackage

[design/igta_ram.sv]
module igta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/igta_scan.sv]
module igta_scan
    import igta_pkg::*;
#(
    parameter int MAX_TRACKS = DEF_MAX_TRACKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          rd_valid,
    input  logic [$clog2(MAX_TRACKS)-1:0] rd_idx,
    input  slot_t                         rd_data,
    input  logic [15:0]                   box_x,
    input  logic [15:0]                   box_y,
    input  logic [14:0]                   box_w,
    input  logic [14:0]                   box_h,
    input  logic [7:0]                    box_class,
    input  logic [8:0]                    iou_threshold,
    input  logic [7:0]                    max_age,
    output logic                          busy,
    output scan_flags_t                   flags,
    output logic [$clog2(MAX_TRACKS)-1:0] best_idx,
    output logic [31:0]                   best_track,
    output logic [$clog2(MAX_TRACKS)-1:0] free_idx
);

    localparam int IDX_W = $clog2(MAX_TRACKS);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic el2_reg, el3_reg, el4_reg, el5_reg;
    logic [31:0] trk2_reg, trk3_reg, trk4_reg, trk5_reg;
    logic [14:0] iw2_reg, ih2_reg, sw2_reg, sh2_reg;
    logic [29:0] inter3_reg, sarea3_reg, inter4_reg, inter5_reg;
    logic [30:0] uni4_reg, uni5_reg;
    logic [60:0] pa5_reg, pb5_reg;
    logic [29:0] area_reg;
    logic [29:0] best_num_reg;
    logic [30:0] best_den_reg;
    logic        best_found_reg, free_found_reg;
    logic [IDX_W-1:0] best_idx_reg, free_idx_reg;
    logic [31:0] best_track_reg;

    logic s1_elig, s1_free;

    // qualify the slot read back from memory
    always_comb
    begin
        s1_elig = rd_data.valid && (rd_data.cls == box_class) && (rd_data.age <= max_age);
        s1_free = !rd_data.valid || (rd_data.age > max_age);
    end

    // datapath stages, no reset needed on payload
    always_ff @(posedge clk)
    begin
        area_reg <= 30'(box_w) * 30'(box_h);

        idx1_reg <= rd_idx;

        idx2_reg <= idx1_reg;
        el2_reg  <= s1_elig;
        trk2_reg <= rd_data.track;
        iw2_reg  <= overlap_1d(box_x, box_w, rd_data.left, rd_data.width);
        ih2_reg  <= overlap_1d(box_y, box_h, rd_data.top, rd_data.height);
        sw2_reg  <= rd_data.width;
        sh2_reg  <= rd_data.height;

        idx3_reg   <= idx2_reg;
        el3_reg    <= el2_reg;
        trk3_reg   <= trk2_reg;
        inter3_reg <= 30'(iw2_reg) * 30'(ih2_reg);
        sarea3_reg <= 30'(sw2_reg) * 30'(sh2_reg);

        idx4_reg   <= idx3_reg;
        el4_reg    <= el3_reg && (inter3_reg != 30'd0);
        trk4_reg   <= trk3_reg;
        inter4_reg <= inter3_reg;
        uni4_reg   <= 31'(area_reg) + 31'(sarea3_reg) - 31'(inter3_reg);

        idx5_reg   <= idx4_reg;
        el5_reg    <= el4_reg;
        trk5_reg   <= trk4_reg;
        inter5_reg <= inter4_reg;
        uni5_reg   <= uni4_reg;
        pa5_reg    <= 61'(inter4_reg) * 61'(best_den_reg);
        pb5_reg    <= 61'(best_num_reg) * 61'(uni4_reg);
    end

    // valid pipe and running best
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_num_reg <= '0;
            best_den_reg <= '0;
            best_idx_reg <= '0;
            free_idx_reg <= '0;
            best_track_reg <= '0;
        end
        else
        begin
            v1_reg <= rd_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (start)
            begin
                best_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
                best_num_reg <= 30'(iou_threshold);
                best_den_reg <= THRESH_DEN;
            end
            else
            begin
                // take the lowest free slot
                if (v1_reg && s1_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg <= idx1_reg;
                end
                // keep a strictly better overlap only
                if (v5_reg && el5_reg && (pa5_reg > pb5_reg))
                begin
                    best_found_reg <= 1'b1;
                    best_num_reg <= inter5_reg;
                    best_den_reg <= uni5_reg;
                    best_idx_reg <= idx5_reg;
                    best_track_reg <= trk5_reg;
                end
            end
        end
    end

    assign busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign flags.best_found = best_found_reg;
    assign flags.free_found = free_found_reg;
    assign best_idx = best_idx_reg;
    assign best_track = best_track_reg;
    assign free_idx = free_idx_reg;

endmodule

[design/iou_greedy_track_assigner_top.sv]
// Greedy IoU track assigner. Slot records live in one synchronous RAM of
// MAX_TRACKS entries. After reset a clearing pass zeroes every entry
// before the first beat is taken. A frame-start beat sweeps the RAM with one
// read-modify-write per cycle. A detection beat reads the slots in turn
// through the overlap and cross-multiply pipeline, whose best-so-far compare
// closes a feedback loop, then writes back at most one record. One beat is
// in work at a time; a finished result waits in the output register.
module iou_greedy_track_assigner_top
    import igta_pkg::*;
#(
    parameter int MAX_TRACKS = DEF_MAX_TRACKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] box_x,
    input  logic [15:0] box_y,
    input  logic [14:0] box_w,
    input  logic [14:0] box_h,
    input  logic [7:0]  box_class,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] track_number,
    output logic        new_track,
    output logic        table_full
);

    localparam int IDX_W = $clog2(MAX_TRACKS);
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TRACKS - 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_TRACKS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AGE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic phase_reg;
    logic age_v_reg;
    logic [IDX_W-1:0] age_idx_reg;
    logic [8:0] thresh_reg;
    logic [7:0] max_age_reg;
    logic [31:0] next_track_reg;
    logic [15:0] x_reg, y_reg;
    logic [14:0] w_reg, h_reg;
    logic [7:0] cls_reg;
    logic out_valid_reg;
    logic [31:0] out_track_reg;
    logic out_new_reg, out_full_reg;

    logic ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    slot_t ram_wdata, ram_rdata, aged;
    logic in_acc, start, scan_issue, scan_busy, out_free;
    scan_flags_t flags;
    logic [IDX_W-1:0] best_idx, free_idx;
    logic [31:0] best_track, next_track_next;

    igta_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_TRACKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    igta_scan #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .rd_valid      (scan_issue),
        .rd_idx        (ram_raddr),
        .rd_data       (ram_rdata),
        .box_x         (x_reg),
        .box_y         (y_reg),
        .box_w         (w_reg),
        .box_h         (h_reg),
        .box_class     (cls_reg),
        .iou_threshold (thresh_reg),
        .max_age       (max_age_reg),
        .busy          (scan_busy),
        .flags         (flags),
        .best_idx      (best_idx),
        .best_track    (best_track),
        .free_idx      (free_idx)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign start = in_acc && (cmd == CMD_DETECT);
    assign scan_issue = (state_reg == ST_SCAN) && !phase_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign ram_raddr = cnt_reg[IDX_W-1:0];

    // skip zero when the id counter wraps
    always_comb
    begin
        next_track_next = next_track_reg + 32'd1;
        if (next_track_next == 32'd0)
        begin
            next_track_next = 32'd1;
        end
    end

    // age one record, saturating
    always_comb
    begin
        aged = ram_rdata;
        if (ram_rdata.valid && (ram_rdata.age != AGE_SAT))
        begin
            aged.age = ram_rdata.age + 8'd1;
        end
    end

    // steer the memory ports
    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = age_idx_reg;
        ram_wdata = aged;
        ram_re = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = cnt_reg[IDX_W-1:0];
                ram_wdata = '0;
            end
            ST_AGE:
            begin
                ram_we = age_v_reg;
                ram_re = (cnt_reg != CNT_END);
            end
            ST_SCAN:
            begin
                ram_re = scan_issue;
            end
            ST_WRITE:
            begin
                ram_we = out_free && (flags.best_found || flags.free_found);
                ram_waddr = flags.best_found ? best_idx : free_idx;
                ram_wdata.valid = 1'b1;
                ram_wdata.left = x_reg;
                ram_wdata.top = y_reg;
                ram_wdata.width = w_reg;
                ram_wdata.height = h_reg;
                ram_wdata.cls = cls_reg;
                ram_wdata.age = 8'd0;
                ram_wdata.track = flags.best_found ? best_track : next_track_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // hold beat payload while it is in work
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= box_x;
            y_reg <= box_y;
            w_reg <= box_w;
            h_reg <= box_h;
            cls_reg <= box_class;
        end
        age_idx_reg <= cnt_reg[IDX_W-1:0];
    end

    // sequencer, registers and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            phase_reg <= 1'b0;
            age_v_reg <= 1'b0;
            thresh_reg <= THRESH_RESET;
            max_age_reg <= MAX_AGE_RESET;
            next_track_reg <= 32'd1;
            out_valid_reg <= 1'b0;
            out_track_reg <= '0;
            out_new_reg <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IOU_THRESHOLD: thresh_reg <= cfg_data;
                    REG_MAX_AGE: max_age_reg <= cfg_data[7:0];
                    default: thresh_reg <= thresh_reg;
                endcase
            end
            // raise a result beat on write-back, drop it once taken
            if ((state_reg == ST_WRITE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            age_v_reg <= ram_re && (state_reg == ST_AGE);
            case (state_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    phase_reg <= 1'b0;
                    if (in_acc)
                    begin
                        state_reg <= (cmd == CMD_DETECT) ? ST_SCAN : ST_AGE;
                    end
                end
                ST_AGE:
                begin
                    if (cnt_reg != CNT_END)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (!age_v_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SCAN:
                begin
                    phase_reg <= !phase_reg;
                    if (scan_issue)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CNT_LAST)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (!scan_busy)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    if (out_free)
                    begin
                        out_new_reg <= !flags.best_found;
                        out_full_reg <= !flags.best_found && !flags.free_found;
                        out_track_reg <= flags.best_found ? best_track : next_track_reg;
                        if (!flags.best_found)
                        begin
                            next_track_reg <= next_track_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign track_number = out_track_reg;
    assign new_track = out_new_reg;
    assign table_full = out_full_reg;

endmodule

[dv/tb_top.sv]
module tb_top
    import igta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = DEF_MAX_TRACKS;
    localparam int SETTLE_CYCLES = 2 * NSLOT + 200;

    typedef struct {
        logic        cmd;
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
        logic [7:0]  cls;
    } box_beat_t;

    typedef struct {
        logic [31:0] id;
        logic        fresh;
        logic        full;
    } id_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = 1'b0;
    logic [15:0] box_x = '0;
    logic [15:0] box_y = '0;
    logic [14:0] box_w = '0;
    logic [14:0] box_h = '0;
    logic [7:0]  box_class = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] track_number;
    logic        new_track;
    logic        table_full;

    iou_greedy_track_assigner_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
        .box_class(box_class),
        .out_valid(out_valid), .out_stall(out_stall),
        .track_number(track_number), .new_track(new_track), .table_full(table_full)
    );

    always #1 clk = ~clk;

    // stimulus and expectations
    box_beat_t  box_queue[$];
    id_result_t due_ids[$];
    box_beat_t  cur_beat;
    int         errors = 0;
    int         in_idle_pct = 0;
    int         out_stall_pct = 0;
    int         hold_cnt = 0;
    bit         hold_go = 1'b0;
    int         n_det = 0, n_frame = 0, n_new = 0, n_match = 0, n_full = 0;

    // tracker model state
    logic [8:0]  thr_reg = THRESH_RESET;
    logic [7:0]  age_limit = MAX_AGE_RESET;
    bit          trk_valid[NSLOT];
    logic [15:0] trk_left[NSLOT];
    logic [15:0] trk_top[NSLOT];
    logic [14:0] trk_width[NSLOT];
    logic [14:0] trk_height[NSLOT];
    logic [7:0]  trk_class[NSLOT];
    logic [7:0]  trk_age[NSLOT];
    logic [31:0] trk_id[NSLOT];
    logic [31:0] next_id = 32'd1;

    // generator's own memory of recent boxes, used to aim detections at tracks
    box_beat_t recent[$];

    function automatic longint unsigned span_overlap(longint a0, longint al,
                                                     longint b0, longint bl);
        longint lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
        return (hi > lo) ? longint'(hi - lo) : 0;
    endfunction

    // advance the tracker model by one accepted beat
    task automatic assign_track(input box_beat_t b);
        longint unsigned area, iw, ih, inter, uni, best_num, best_den;
        int best, dst;
        id_result_t r;
        if (b.cmd == CMD_FRAME) begin
            for (int i = 0; i < NSLOT; i++)
                if (trk_valid[i] && trk_age[i] != AGE_SAT)
                    trk_age[i] = trk_age[i] + 8'd1;
            n_frame++;
            return;
        end
        area = longint'(b.w) * longint'(b.h);
        best_num = thr_reg;
        best_den = 256;
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (!trk_valid[i] || trk_class[i] != b.cls || trk_age[i] > age_limit)
                continue;
            iw = span_overlap($signed(b.x), b.w, $signed(trk_left[i]), trk_width[i]);
            ih = span_overlap($signed(b.y), b.h, $signed(trk_top[i]), trk_height[i]);
            inter = iw * ih;
            if (inter == 0)
                continue;
            uni = area + longint'(trk_width[i]) * longint'(trk_height[i]) - inter;
            if (inter * best_den > best_num * uni) begin
                best_num = inter;
                best_den = uni;
                best = i;
            end
        end
        r.fresh = 1'b0;
        r.full = 1'b0;
        if (best >= 0) begin
            dst = best;
            r.id = trk_id[dst];
        end
        else begin
            r.fresh = 1'b1;
            r.id = next_id;
            next_id = next_id + 32'd1;
            if (next_id == 32'd0)
                next_id = 32'd1;
            dst = -1;
            for (int i = 0; i < NSLOT; i++)
                if (dst < 0 && (!trk_valid[i] || trk_age[i] > age_limit))
                    dst = i;
            if (dst < 0)
                r.full = 1'b1;
        end
        if (dst >= 0) begin
            trk_valid[dst] = 1'b1;
            trk_left[dst] = b.x;
            trk_top[dst] = b.y;
            trk_width[dst] = b.w;
            trk_height[dst] = b.h;
            trk_class[dst] = b.cls;
            trk_age[dst] = 8'd0;
            trk_id[dst] = r.id;
        end
        n_det++;
        if (r.full) n_full++;
        if (r.fresh) n_new++; else n_match++;
        due_ids.insert(due_ids.size(), r);
    endtask

    // driver: predict on each accepted beat, then offer the next one or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall) begin
            if (in_valid)
                assign_track(cur_beat);
            if (box_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                cur_beat = box_queue.pop_front();
                in_valid <= 1'b1;
                cmd <= cur_beat.cmd;
                box_x <= cur_beat.x;
                box_y <= cur_beat.y;
                box_w <= cur_beat.w;
                box_h <= cur_beat.h;
                box_class <= cur_beat.cls;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_go)
            hold_cnt <= 3000;
    end

    // monitor: check each accepted result beat, then pick the next stall
    always @(posedge clk) begin
        id_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (due_ids.size() == 0) begin
                report_mismatch($sformatf("unexpected result id %0d", track_number));
            end
            else begin
                e = due_ids.pop_front();
                if (track_number !== e.id)
                    report_mismatch($sformatf("track_number %0d, want %0d",
                                              track_number, e.id));
                if (new_track !== e.fresh)
                    report_mismatch($sformatf("new_track %b, want %b (id %0d)",
                                              new_track, e.fresh, e.id));
                if (table_full !== e.full)
                    report_mismatch($sformatf("table_full %b, want %b (id %0d)",
                                              table_full, e.full, e.id));
            end
        end
        out_stall <= (hold_cnt > 1) || ($urandom_range(99) < out_stall_pct);
    end

    task automatic push_box(input logic c, input int x, input int y, input int w,
                            input int h, input int cls);
        box_beat_t b;
        b.cmd = c;
        b.x = 16'(x);
        b.y = 16'(y);
        b.w = 15'(w);
        b.h = 15'(h);
        b.cls = 8'(cls);
        box_queue.insert(box_queue.size(), b);
        if (c == CMD_DETECT) begin
            recent.insert(recent.size(), b);
            if (recent.size() > NSLOT)
                void'(recent.pop_front());
        end
    endtask

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // detection jittered around a recently seen box
    task automatic push_near();
        box_beat_t r;
        int j;
        if (recent.size() == 0) begin
            push_box(CMD_DETECT, $urandom_range(2000), $urandom_range(2000), 40, 40, 1);
            return;
        end
        r = recent[$urandom_range(recent.size() - 1)];
        j = $urandom_range(8);
        push_box(CMD_DETECT,
                 clamp(int'($signed(r.x)) + $urandom_range(2 * j) - j, -32768, 32767),
                 clamp(int'($signed(r.y)) + $urandom_range(2 * j) - j, -32768, 32767),
                 clamp(int'(r.w) + $urandom_range(2 * j) - j, 0, 32767),
                 clamp(int'(r.h) + $urandom_range(2 * j) - j, 0, 32767),
                 ($urandom_range(19) == 0) ? $urandom_range(255) : r.cls);
    endtask

    task automatic push_fresh();
        push_box(CMD_DETECT, $urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                 $urandom_range(1, 200), $urandom_range(1, 200), $urandom_range(3));
    endtask

    task automatic push_noise();
        push_box($urandom_range(1), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(32767), $urandom_range(32767), $urandom_range(255));
    endtask

    // frames of tracked boxes with random content, plus noise
    task automatic push_mix(input int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 12) push_box(CMD_FRAME, 0, 0, 0, 0, 0);
            else if (k < 62) push_near();
            else if (k < 85) push_fresh();
            else push_noise();
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (box_queue.size() != 0 || in_valid || due_ids.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 9'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IOU_THRESHOLD) thr_reg = 9'(value);
        else age_limit = 8'(value);
    endtask

    task automatic set_mode(input int m);
        case (m % 4)
            0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1: begin in_idle_pct = 71; out_stall_pct = 0;  end
            2: begin in_idle_pct = 0;  out_stall_pct = 71; end
            default: begin in_idle_pct = 16; out_stall_pct = 16; end
        endcase
    endtask

    int thr_set[7] = '{77, 0, 256, 511, 128, 20, 200};
    int age_set[7] = '{30, 0, 254, 10, 255, 5, 254};

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero area, touching edges, class split
        set_mode(0);
        push_box(CMD_DETECT, -32768, -32768, 32767, 32767, 255);
        push_box(CMD_DETECT, -32768, -32768, 32767, 32767, 255);
        push_box(CMD_DETECT, 32767, 32767, 32767, 32767, 255);
        push_box(CMD_DETECT, 100, 100, 0, 50, 2);
        push_box(CMD_DETECT, 100, 100, 0, 50, 2);
        push_box(CMD_DETECT, 100, 100, 50, 0, 2);
        push_box(CMD_DETECT, 10, 10, 20, 20, 0);
        push_box(CMD_DETECT, 30, 10, 20, 20, 0);
        push_box(CMD_DETECT, 10, 30, 20, 20, 0);
        push_box(CMD_FRAME, 0, 0, 0, 0, 0);
        push_box(CMD_DETECT, 12, 11, 20, 20, 0);
        push_box(CMD_DETECT, 12, 11, 20, 20, 1);
        push_box(CMD_DETECT, 0, 0, 1, 1, 0);
        push_box(CMD_DETECT, 0, 0, 1, 1, 0);
        push_box(CMD_DETECT, -1, -1, 32767, 1, 9);
        push_box(CMD_DETECT, 0, -1, 32767, 1, 9);
        wait_idle();

        // random phases over register settings and idling styles
        for (int p = 0; p < 7; p++) begin
            write_reg(REG_IOU_THRESHOLD, thr_set[p]);
            write_reg(REG_MAX_AGE, age_set[p]);
            set_mode(p);
            if (p == 0) begin
                push_mix(60);
                hold_go = 1'b1;
                while (hold_cnt == 0) @(posedge clk);
                hold_go = 1'b0;
            end
            push_mix(30);
            wait_idle();
        end

        // fill every slot with disjoint boxes until no slot is free
        write_reg(REG_IOU_THRESHOLD, 77);
        write_reg(REG_MAX_AGE, 254);
        set_mode(3);
        for (int i = 0; i < NSLOT + 6; i++)
            push_box(CMD_DETECT, i * 200 - 8000, 5000, 50, 50, 7);
        push_near();
        push_box(CMD_FRAME, 0, 0, 0, 0, 0);
        push_box(CMD_DETECT, 0, 5000, 50, 50, 7);
        wait_idle();

        // age past saturation with a limit of 255, then revisit old tracks
        write_reg(REG_MAX_AGE, 255);
        set_mode(1);
        for (int i = 0; i < 258; i++)
            push_box(CMD_FRAME, 0, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            push_near();
        push_box(CMD_DETECT, 1, 5000, 50, 50, 7);
        wait_idle();
        write_reg(REG_MAX_AGE, 254);
        set_mode(2);
        push_box(CMD_DETECT, 2, 5000, 50, 50, 7);
        push_mix(20);
        wait_idle();

        $display("covered %0d detections (%0d new, %0d matched, %0d table full)",
                 n_det, n_new, n_match, n_full);
        $display("covered %0d frame starts over 9 register settings", n_frame);
        if (errors == 0)
            $display("iou_greedy_track_assigner_top regression: pass");
        else
            $display("iou_greedy_track_assigner_top regression: fail");
        $finish;
    end

    // stop a hung run
    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", due_ids.size());
        $display("iou_greedy_track_assigner_top regression: fail");
        $finish;
    end

endmodule

[files.f]
design/igta_pkg.sv
design/igta_ram.sv
design/igta_scan.sv
design/iou_greedy_track_assigner_top.sv
dv/tb_top.sv
